@@ hdl/bsrh_pkg.sv @@
`default_nettype none
package bsrh_pkg;

  // Default configuration of the block
  localparam int MAX_BINS_DEF    = 64;
  localparam int COUNT_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int ORIGIN_W = 32;
  localparam int WIDTH_W  = 31;
  localparam int BINS_W   = 7;
  localparam int DIFF_W   = ORIGIN_W + 1;
  localparam int SPAN_W   = BINS_W + WIDTH_W;
  localparam int RATIO_W  = 17;
  localparam int QUO_W    = 16;
  localparam int STEP_W   = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(65536);
  localparam logic [STEP_W-1:0]  RATIO_STEPS = STEP_W'(QUO_W);

  // Commands
  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_ORIGIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BIN,
    ST_CHECK,
    ST_BDIV,
    ST_BREAD,
    ST_BWRITE,
    ST_RREAD,
    ST_RDATA,
    ST_RDIV
  } state_t;

  // Divider control
  typedef struct packed {
    logic              start;
    logic              shift_rem;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

  // Counter memory control
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage
`default_nettype wire

@@ hdl/bsrh_div.sv @@
`default_nettype none
module bsrh_div
  import bsrh_pkg::*;
#(
  parameter int DW = 37
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire div_req_t      req,
  input  wire logic [DW-1:0] num,
  input  wire logic [DW-1:0] den,
  output div_rsp_t           rsp
);

  logic              active_r;
  logic              done_r;
  logic [STEP_W-1:0] cnt_r;
  logic              mode_r;
  logic [DW-1:0]     rem_r;
  logic [DW-1:0]     dvs_r;
  logic [QUO_W-1:0]  quo_r;

  logic          ge;
  logic [DW-1:0] rem_sub;

  // Compare and subtract one quotient bit
  assign ge      = (rem_r >= dvs_r);
  assign rem_sub = ge ? (rem_r - dvs_r) : rem_r;

  // Step counter and completion strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        active_r <= 1'b1;
        cnt_r    <= req.steps;
      end else if (active_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  // Remainder, divisor and quotient
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= num;
      dvs_r  <= den;
      mode_r <= req.shift_rem;
      quo_r  <= '0;
    end else if (active_r) begin
      quo_r <= {quo_r[QUO_W-2:0], ge};
      if (mode_r) begin
        rem_r <= {rem_sub[DW-2:0], 1'b0};
      end else begin
        rem_r <= rem_sub;
        dvs_r <= dvs_r >> 1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !active_r)
    else $error("divider started while active");

  a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && cnt_r == STEP_W'(1) && !req.start) |=> done_r)
    else $error("divider missed completion");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !active_r)
    else $error("divider done while still active");

endmodule
`default_nettype wire

@@ hdl/bsrh_count_mem.sv @@
`default_nettype none
module bsrh_count_mem
  import bsrh_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int CW    = 32,
  parameter int AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire mem_ctl_t      ctl,
  input  wire logic [AW-1:0] addr,
  input  wire logic [CW-1:0] wr_total,
  input  wire logic [CW-1:0] wr_success,
  output logic [CW-1:0]      rd_total,
  output logic [CW-1:0]      rd_success
);

  logic [CW-1:0]    total_mem   [DEPTH];
  logic [CW-1:0]    success_mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic             rd_valid_r;
  logic [CW-1:0]    rd_total_r;
  logic [CW-1:0]    rd_success_r;

  // Mark entries written since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        valid_r[addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_valid_r <= valid_r[addr];
      end
    end
  end

  // Synchronous counter arrays
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      total_mem[addr]   <= wr_total;
      success_mem[addr] <= wr_success;
    end
    if (ctl.rd_en) begin
      rd_total_r   <= total_mem[addr];
      rd_success_r <= success_mem[addr];
    end
  end

  // Unwritten entries read as zero
  assign rd_total   = rd_valid_r ? rd_total_r : '0;
  assign rd_success = rd_valid_r ? rd_success_r : '0;

endmodule
`default_nettype wire

@@ hdl/binned_success_ratio_histogram.sv @@
`default_nettype none
// Channel   Handshake              Payload
// input     start / busy           in_command, in_sample_value, in_succeeded
// result    out_valid strobe       out_bin_index, out_ratio, out_out_of_range, out_last
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item at a time; busy is high from the cycle after start until the item is done
// (a report with no bins in use ends at once and never raises busy).
// Add: an out-of-range sample ends without the divider; otherwise the bin index comes
// from the shared iterative divider, one quotient bit per cycle.
// Report: a bin with a zero or full ratio skips the divider, any other takes 16 divider
// steps; min(bin_count, MAX_BINS) bins in all. Counters clear at reset through
// per-entry valid bits.
// Reset is synchronous, active low. Results are single-cycle strobes; no back-pressure.
module binned_success_ratio_histogram
  import bsrh_pkg::*;
#(
  parameter int MAX_BINS    = MAX_BINS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  in_command,
  input  wire logic signed [31:0]    in_sample_value,
  input  wire logic                  in_succeeded,
  output logic                       out_valid,
  output logic [5:0]                 out_bin_index,
  output logic [RATIO_W-1:0]         out_ratio,
  output logic                       out_out_of_range,
  output logic                       out_last,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int DIV_W = (COUNT_WIDTH + 1 > WIDTH_W + IDX_W) ?
                         COUNT_WIDTH + 1 : WIDTH_W + IDX_W;

  state_t state_r, state_nxt;

  logic [ORIGIN_W-1:0]    origin_r;
  logic [WIDTH_W-1:0]     width_r;
  logic [BINS_W-1:0]      count_r;
  logic [ORIGIN_W-1:0]    sample_r;
  logic                   succ_r;
  logic [DIFF_W-1:0]      diff_r;
  logic [SPAN_W-1:0]      span_r;
  logic [IDX_W-1:0]       idx_r;
  logic                   out_valid_r;
  logic [5:0]             out_bin_r;
  logic [RATIO_W-1:0]     out_ratio_r;
  logic                   out_oor_r;
  logic                   out_last_r;

  logic [BINS_W-1:0]      bins_n;
  logic [WIDTH_W-1:0]     w_eff;
  logic                   in_range;
  logic                   is_last;
  logic                   t_zero;
  logic                   s_full;
  logic [COUNT_WIDTH-1:0] rd_total;
  logic [COUNT_WIDTH-1:0] rd_success;
  logic [COUNT_WIDTH-1:0] tot_inc;
  logic [COUNT_WIDTH-1:0] suc_inc;

  div_req_t               div_req;
  div_rsp_t               div_rsp;
  logic [DIV_W-1:0]       div_num;
  logic [DIV_W-1:0]       div_den;
  mem_ctl_t               mem_ctl;

  logic                   emit;
  logic                   emit_oor;
  logic [RATIO_W-1:0]     emit_ratio;
  logic                   adv_idx;

  // Effective configuration
  assign bins_n = (count_r > BINS_W'(MAX_BINS)) ? BINS_W'(MAX_BINS) : count_r;
  assign w_eff  = (width_r == '0) ? WIDTH_W'(1) : width_r;

  assign in_range = !diff_r[DIFF_W-1] && (SPAN_W'(diff_r[DIFF_W-2:0]) < span_r);
  assign is_last  = ((BINS_W'(idx_r) + BINS_W'(1)) == bins_n);
  assign t_zero   = (rd_total == '0);
  assign s_full   = (rd_success >= rd_total);

  // Saturating increments
  assign tot_inc = (&rd_total) ? rd_total : rd_total + COUNT_WIDTH'(1);
  assign suc_inc = (succ_r && !(&rd_success)) ? rd_success + COUNT_WIDTH'(1) : rd_success;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r <= '0;
      width_r  <= WIDTH_W'(65536);
      count_r  <= BINS_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BIN_ORIGIN: origin_r <= cfg_data;
        CFG_BIN_WIDTH:  width_r  <= cfg_data[WIDTH_W-1:0];
        CFG_BIN_COUNT:  count_r  <= cfg_data[BINS_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_command == CMD_ADD) begin
            state_nxt = ST_BIN;
          end else if (bins_n != '0) begin
            state_nxt = ST_RREAD;
          end
        end
      end
      ST_BIN:    state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = in_range ? ST_BDIV : ST_IDLE;
      ST_BDIV:   if (div_rsp.done) state_nxt = ST_BREAD;
      ST_BREAD:  state_nxt = ST_BWRITE;
      ST_BWRITE: state_nxt = ST_IDLE;
      ST_RREAD:  state_nxt = ST_RDATA;
      ST_RDATA: begin
        if (t_zero || s_full) begin
          state_nxt = is_last ? ST_IDLE : ST_RREAD;
        end else begin
          state_nxt = ST_RDIV;
        end
      end
      ST_RDIV: begin
        if (div_rsp.done) begin
          state_nxt = is_last ? ST_IDLE : ST_RREAD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    emit          = 1'b0;
    emit_oor      = 1'b0;
    emit_ratio    = '0;
    adv_idx       = 1'b0;
    mem_ctl       = '0;
    div_req       = '0;
    div_num       = DIV_W'(diff_r[DIFF_W-2:0]);
    div_den       = DIV_W'(w_eff) << (IDX_W - 1);
    unique case (state_r)
      ST_CHECK: begin
        if (in_range) begin
          div_req.start     = 1'b1;
          div_req.shift_rem = 1'b0;
          div_req.steps     = STEP_W'(IDX_W);
        end else begin
          emit     = 1'b1;
          emit_oor = 1'b1;
        end
      end
      ST_BREAD:  mem_ctl.rd_en = 1'b1;
      ST_BWRITE: begin
        mem_ctl.wr_en = 1'b1;
        emit          = 1'b1;
      end
      ST_RREAD:  mem_ctl.rd_en = 1'b1;
      ST_RDATA: begin
        div_num = DIV_W'(rd_success) << 1;
        div_den = DIV_W'(rd_total);
        if (t_zero || s_full) begin
          emit       = 1'b1;
          emit_ratio = t_zero ? '0 : RATIO_ONE;
          adv_idx    = !is_last;
        end else begin
          div_req.start     = 1'b1;
          div_req.shift_rem = 1'b1;
          div_req.steps     = RATIO_STEPS;
        end
      end
      ST_RDIV: begin
        if (div_rsp.done) begin
          emit       = 1'b1;
          emit_ratio = RATIO_W'(div_rsp.quo);
          adv_idx    = !is_last;
        end
      end
      default: ;
    endcase
  end

  // State and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      sample_r <= in_sample_value;
      succ_r   <= in_succeeded;
      idx_r    <= '0;
    end
    if (state_r == ST_BIN) begin
      diff_r <= {sample_r[ORIGIN_W-1], sample_r} - {origin_r[ORIGIN_W-1], origin_r};
      span_r <= SPAN_W'(bins_n) * SPAN_W'(w_eff);
    end
    if (state_r == ST_BDIV && div_rsp.done) begin
      idx_r <= div_rsp.quo[IDX_W-1:0];
    end
    if (adv_idx) begin
      idx_r <= idx_r + IDX_W'(1);
    end
    if (emit) begin
      out_oor_r   <= emit_oor;
      out_ratio_r <= emit_ratio;
      out_bin_r   <= (state_r == ST_RDATA || state_r == ST_RDIV) ? 6'(idx_r) : 6'd0;
      out_last_r  <= (state_r == ST_RDATA || state_r == ST_RDIV) ? is_last : 1'b1;
    end
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_bin_index    = out_bin_r;
  assign out_ratio        = out_ratio_r;
  assign out_out_of_range = out_oor_r;
  assign out_last         = out_last_r;

  bsrh_div #(
    .DW (DIV_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .num   (div_num),
    .den   (div_den),
    .rsp   (div_rsp)
  );

  bsrh_count_mem #(
    .DEPTH (MAX_BINS),
    .CW    (COUNT_WIDTH),
    .AW    (IDX_W)
  ) u_mem (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (mem_ctl),
    .addr       (idx_r),
    .wr_total   (tot_inc),
    .wr_success (suc_inc),
    .rd_total   (rd_total),
    .rd_success (rd_success)
  );

  a_oor_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |->
      (out_last && out_ratio == '0 && out_bin_index == 6'd0))
    else $error("out-of-range result with report fields");

  a_ratio_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ratio <= RATIO_ONE))
    else $error("ratio above one");

  a_add_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_command == CMD_ADD) |=> busy)
    else $error("add transaction not taken");

  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BWRITE) |=> (out_valid && out_last && !out_out_of_range))
    else $error("counted add gave no result");

endmodule
`default_nettype wire

@@ test/bsrh_checker.sv @@
`timescale 1ns / 1ps
module bsrh_checker
  import bsrh_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic                  busy,
  input  wire logic                  in_command,
  input  wire logic signed [31:0]    in_sample_value,
  input  wire logic                  in_succeeded,
  input  wire logic                  out_valid,
  input  wire logic [5:0]            out_bin_index,
  input  wire logic [RATIO_W-1:0]    out_ratio,
  input  wire logic                  out_out_of_range,
  input  wire logic                  out_last,
  input  wire logic                  cfg_valid,
  input  wire logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         results_due
);

  localparam int NBINS = MAX_BINS_DEF;
  localparam int CW    = COUNT_WIDTH_DEF;

  typedef struct {
    logic [5:0]         bin;
    logic [RATIO_W-1:0] ratio;
    logic               oor;
    logic               last;
  } bin_result_t;

  // Shadow copy of the configuration and the per-bin counters
  logic signed [31:0] origin_q;
  logic [30:0]        width_q;
  logic [6:0]         count_q;
  logic [CW-1:0]      total_cnt   [NBINS];
  logic [CW-1:0]      success_cnt [NBINS];

  bin_result_t bin_results_due[$];
  bin_result_t head;
  int          mismatches = 0;

  function automatic int unsigned bins_used();
    return (count_q > NBINS) ? NBINS : count_q;
  endfunction

  // floor(success * 1.0 / total) in Q1.16, zero for an empty bin
  function automatic logic [RATIO_W-1:0] success_ratio(input logic [CW-1:0] succ,
                                                        input logic [CW-1:0] tot);
    logic [CW+15:0] scaled;
    if (tot == 0) return '0;
    if (succ >= tot) return RATIO_ONE;
    scaled = {succ, 16'd0};
    return RATIO_W'(scaled / tot);
  endfunction

  // Append one expected result transaction
  task automatic queue_result(input bin_result_t r);
    bin_results_due.insert(bin_results_due.size(), r);
  endtask

  // Bin one sample and count it; queue the single add result
  task automatic count_sample(input logic signed [31:0] sample, input logic succ);
    logic signed [32:0] diff;
    logic [32:0]        idx;
    logic [30:0]        w;
    logic               oor;
    bin_result_t        r;
    diff = {sample[31], sample} - {origin_q[31], origin_q};
    w    = (width_q == 0) ? 31'd1 : width_q;
    oor  = 1'b1;
    if (!diff[32]) begin
      idx = $unsigned(diff) / {2'b00, w};
      if (idx < 33'(bins_used())) begin
        oor = 1'b0;
        if (total_cnt[idx[5:0]] != {CW{1'b1}}) total_cnt[idx[5:0]]++;
        if (succ && success_cnt[idx[5:0]] != {CW{1'b1}}) success_cnt[idx[5:0]]++;
      end
    end
    r.bin   = '0;
    r.ratio = '0;
    r.oor   = oor;
    r.last  = 1'b1;
    queue_result(r);
  endtask

  // Queue one ratio result per bin in use
  task automatic report_ratios();
    bin_result_t r;
    int unsigned n;
    n = bins_used();
    for (int unsigned i = 0; i < n; i++) begin
      r.bin   = i[5:0];
      r.ratio = success_ratio(success_cnt[i], total_cnt[i]);
      r.oor   = 1'b0;
      r.last  = (i + 1 == n);
      queue_result(r);
    end
  endtask

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      origin_q = '0;
      width_q  = 31'd65536;
      count_q  = 7'd64;
      for (int i = 0; i < NBINS; i++) begin
        total_cnt[i]   = '0;
        success_cnt[i] = '0;
      end
      bin_results_due.delete();
      results_due <= 0;
      fail_count  <= 0;
    end else begin
      // Compare a result transaction with the oldest expectation
      if (out_valid) begin
        if (bin_results_due.size() == 0) begin
          mismatches++;
          $display("%0t unexpected result: expected none, actual bin %0d ratio %0d",
                   $time, out_bin_index, out_ratio);
        end else begin
          head = bin_results_due.pop_front();
          check_field("bin_index", head.bin, out_bin_index);
          check_field("ratio", head.ratio, out_ratio);
          check_field("out_of_range", head.oor, out_out_of_range);
          check_field("last", head.last, out_last);
        end
      end

      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BIN_ORIGIN: origin_q = cfg_data;
          CFG_BIN_WIDTH:  width_q  = cfg_data[30:0];
          CFG_BIN_COUNT:  count_q  = cfg_data[6:0];
          default: ;
        endcase
      end

      // Predict results of an accepted item
      if (start && !busy) begin
        if (in_command == CMD_ADD) count_sample(in_sample_value, in_succeeded);
        else report_ratios();
      end

      results_due <= bin_results_due.size();
      fail_count  <= mismatches;
    end
  end

endmodule

@@ test/binned_success_ratio_histogram_test.sv @@
`timescale 1ns / 1ps
module binned_success_ratio_histogram_test
  import bsrh_pkg::*;
();

  // Index that maps to no register
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_command = CMD_ADD;
  logic signed [31:0]    in_sample_value = '0;
  logic                  in_succeeded = 1'b0;
  logic                  out_valid;
  logic [5:0]            out_bin_index;
  logic [RATIO_W-1:0]    out_ratio;
  logic                  out_out_of_range;
  logic                  out_last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_BIN_ORIGIN;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    results_due;

  // Stimulus-side view of the grid, used to aim samples at bins
  logic signed [31:0]    grid_origin = '0;
  logic [30:0]           grid_width = 31'd65536;
  logic [6:0]            grid_count = 7'd64;
  int                    burst_left = 0;
  int                    success_pct = 50;
  int                    items_sent = 0;

  binned_success_ratio_histogram uut (
    .clk, .rst_n, .start, .busy, .in_command, .in_sample_value, .in_succeeded,
    .out_valid, .out_bin_index, .out_ratio, .out_out_of_range, .out_last,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  bsrh_checker u_checker (
    .clk, .rst_n, .start, .busy, .in_command, .in_sample_value, .in_succeeded,
    .out_valid, .out_bin_index, .out_ratio, .out_out_of_range, .out_last,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fail_count, .results_due
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one item; the sender works in bursts with random gaps between them
  task automatic send_item(input logic cmd, input logic [31:0] value, input logic succ);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start           <= 1'b0;
        in_command      <= 1'($urandom);
        in_sample_value <= $urandom;
        in_succeeded    <= 1'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start           <= 1'b1;
    in_command      <= cmd;
    in_sample_value <= value;
    in_succeeded    <= succ;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // Write one register once the block has drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    start <= 1'b0;
    do @(posedge clk); while (results_due != 0 || busy);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_BIN_ORIGIN: grid_origin = data;
      CFG_BIN_WIDTH:  grid_width  = data[30:0];
      CFG_BIN_COUNT:  grid_count  = data[6:0];
      default: ;
    endcase
    burst_left = 0;
  endtask

  // Mostly aim at a bin near the grid, including edges and just past the end
  function automatic logic [31:0] pick_sample();
    longint      w, pos;
    int unsigned nb, b;
    w  = (grid_width == 0) ? 1 : longint'(grid_width);
    nb = (grid_count > 64) ? 64 : grid_count;
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: pos = longint'(grid_origin) - $urandom_range(1, 70000);
      default: begin
        b   = $urandom_range(0, nb + 1);
        pos = longint'(grid_origin) + longint'(b) * w;
        case ($urandom_range(0, 3))
          0: ;
          1: pos = pos + w - 1;
          default: pos = pos + (longint'($urandom) % w);
        endcase
      end
    endcase
    if (pos < -64'sd2147483648 || pos > 64'sd2147483647) return $urandom;
    return pos[31:0];
  endfunction

  function automatic logic [31:0] pick_origin();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return $urandom;
      default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  function automatic logic [31:0] pick_width();
    logic [30:0] w;
    case ($urandom_range(0, 7))
      0: w = 31'd1;
      1: w = 31'h7FFF_FFFF;
      2: w = 31'd0;
      3: w = 31'd65536;
      4: w = 31'($urandom);
      default: w = 31'($urandom_range(1, 1 << 20));
    endcase
    return {1'($urandom), w};
  endfunction

  function automatic logic [31:0] pick_count();
    logic [6:0] c;
    case ($urandom_range(0, 9))
      0: c = 7'd1;
      1: c = 7'd64;
      2: c = 7'd0;
      3: c = 7'd127;
      4: c = 7'($urandom_range(65, 126));
      5: c = 7'($urandom_range(1, 64));
      default: c = 7'($urandom_range(1, 12));
    endcase
    return {25'($urandom), c};
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default grid: bin edges, negative side, beyond the grid, field extremes
    send_item(CMD_ADD, 32'h0000_0000, 1'b1);
    send_item(CMD_ADD, 32'h0000_FFFF, 1'b0);
    send_item(CMD_ADD, 32'hFFFF_FFFF, 1'b1);
    send_item(CMD_ADD, 32'h003F_8000, 1'b1);
    send_item(CMD_ADD, 32'h0040_0000, 1'b1);
    send_item(CMD_ADD, 32'h7FFF_FFFF, 1'b1);
    send_item(CMD_ADD, 32'h8000_0000, 1'b0);
    send_item(CMD_ADD, 32'h0001_0000, 1'b1);
    send_item(CMD_ADD, 32'h0001_8000, 1'b1);
    send_item(CMD_ADD, 32'h0001_C000, 1'b0);
    send_item(CMD_REPORT, 32'h0, 1'b0);

    // Lowest origin, zero width taken as one, too many bins clipped
    write_reg(CFG_BIN_ORIGIN, 32'h8000_0000);
    write_reg(CFG_BIN_WIDTH, 32'h0000_0000);
    write_reg(CFG_BIN_COUNT, 32'd100);
    send_item(CMD_ADD, 32'h8000_0000, 1'b1);
    send_item(CMD_ADD, 32'h8000_003F, 1'b1);
    send_item(CMD_ADD, 32'h8000_0040, 1'b0);
    send_item(CMD_ADD, 32'h7FFF_FFFF, 1'b1);
    send_item(CMD_REPORT, 32'h0, 1'b0);

    // Widest bins, single bin in use
    write_reg(CFG_BIN_WIDTH, 32'hFFFF_FFFF);
    write_reg(CFG_BIN_COUNT, 32'd1);
    send_item(CMD_ADD, 32'hFFFF_FFFF, 1'b1);
    send_item(CMD_ADD, 32'hFFFF_FFFE, 1'b0);
    send_item(CMD_REPORT, 32'h0, 1'b1);

    // No bins in use: add is out of range, report yields nothing
    write_reg(CFG_BIN_COUNT, 32'd0);
    send_item(CMD_ADD, 32'h8000_0000, 1'b1);
    send_item(CMD_REPORT, 32'h0, 1'b0);
    write_reg(CFG_NO_REG, $urandom);

    // Highest origin
    write_reg(CFG_BIN_ORIGIN, 32'h7FFF_FFFF);
    write_reg(CFG_BIN_WIDTH, 32'd1);
    write_reg(CFG_BIN_COUNT, 32'd64);
    send_item(CMD_ADD, 32'h7FFF_FFFF, 1'b1);
    send_item(CMD_ADD, 32'h7FFF_FFFE, 1'b1);
    send_item(CMD_REPORT, 32'h0, 1'b0);

    // Random phases: a fresh grid, then a batch of aimed adds and some reports
    while (items_sent < 280) begin
      if ($urandom_range(0, 3) != 0) write_reg(CFG_BIN_ORIGIN, pick_origin());
      if ($urandom_range(0, 3) != 0) write_reg(CFG_BIN_WIDTH, pick_width());
      if ($urandom_range(0, 3) != 0) write_reg(CFG_BIN_COUNT, pick_count());
      success_pct = $urandom_range(0, 100);
      repeat ($urandom_range(15, 40)) begin
        if ($urandom_range(0, 9) == 0)
          send_item(CMD_REPORT, $urandom, 1'($urandom));
        else
          send_item(CMD_ADD, pick_sample(), $urandom_range(0, 99) < success_pct);
      end
      send_item(CMD_REPORT, $urandom, 1'($urandom));
    end

    // Drain and let the block settle
    start <= 1'b0;
    do @(posedge clk); while (results_due != 0 || busy);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("[binned_success_ratio_histogram] OK");
    end else begin
      $display("[binned_success_ratio_histogram] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("[binned_success_ratio_histogram] ERROR");
    $finish;
  end

endmodule
